/* sv/anagram_checker_macros.svh */
// ----------------------------------------------------------------------------
// Anagram checker assertion macros
// Concurrent checks on the clock and reset of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef ANAGRAM_CHECKER_MACROS_SVH
`define ANAGRAM_CHECKER_MACROS_SVH
`ifndef SYNTHESIS
// Check a property in the same cycle as its trigger.
`define ANACHK_ASSERT_NOW(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("anagram_checker: same-cycle check failed");
// Check a property in the cycle after its trigger.
`define ANACHK_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("anagram_checker: next-cycle check failed");
`else
`define ANACHK_ASSERT_NOW(label, cond, prop)
`define ANACHK_ASSERT_NEXT(label, cond, prop)
`endif
`endif

/* sv/anachk_pkg.sv */
// ----------------------------------------------------------------------------
// Anagram checker package
// Item types and fixed codes shared by the anagram checker modules.
// ----------------------------------------------------------------------------
package anachk_pkg;

   localparam int SYM_W  = 8;           // symbol byte width
   localparam int KIND_W = 2;
   localparam int NZ_W   = SYM_W + 1;   // nonzero count spans 0 .. 2**SYM_W

   // Item kinds; the fourth code is ignored.
   localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SYM_W-1:0]  symbol;
   } req_type;

   typedef struct packed {
      logic is_match;
      logic too_long;
   } rsp_type;

endpackage

/* sv/anagram_checker.sv */
// ----------------------------------------------------------------------------
// Anagram checker
// Decides whether two words are anagrams by a per-symbol count histogram.
// ----------------------------------------------------------------------------
// Usage:
//   Send the bytes of the first word (kind first) and of the second word
//   (kind second) on req_, in any interleaving, then one end item. Each end
//   item gives one rsp_ item: is_match when both lengths agree, no word passed
//   MAX_WORD_LEN and every count is back at zero; too_long when a word got
//   more than MAX_WORD_LEN bytes. Items of the unused kind are taken and dropped.
// Timing:
//   One byte item per cycle: read the count at accept, then adjust and write
//   it back in the next cycle, forwarding the previous write on the same symbol.
//   rsp_valid rises once an end item has passed the update stage into the
//   result register. The next end item waits out the update stage, then a
//   full result register: end items are never back to back. Bytes are never held.
// Stall and reset:
//   The result waits in an output register while rsp_ready is low; bytes keep
//   flowing. Reset and each end item clear every count at once through
//   per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "anagram_checker_macros.svh"

module anagram_checker #(
   parameter int MAX_WORD_LEN = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  anachk_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output anachk_pkg::rsp_type  rsp_data
);
   import anachk_pkg::*;

   localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
   // Counts stay within -MAX_WORD_LEN .. MAX_WORD_LEN, plus a sign bit.
   localparam int CNT_W = LEN_W + 1;
   localparam int DEPTH = 1 << SYM_W;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WORD_LEN);

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_ADD  = 2'd1,
      OP_SUB  = 2'd2,
      OP_END  = 2'd3
   } op_type;

   // Front stage: word lengths and overflow flag.
   logic [LEN_W-1:0] first_len_ff, first_len_in;
   logic [LEN_W-1:0] second_len_ff, second_len_in;
   logic             ovf_ff, ovf_in;

   // Update stage.
   op_type           s2_op_ff, s2_op_in;
   logic [SYM_W-1:0] s2_sym_ff, s2_sym_in;
   logic             s2_eq_ff, s2_eq_in;
   logic             s2_ovf_ff, s2_ovf_in;

   // Count store bookkeeping.
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [NZ_W-1:0]  nz_ff, nz_in;
   logic             fwd_valid_ff, fwd_valid_in;
   logic [SYM_W-1:0] fwd_sym_ff, fwd_sym_in;
   logic [CNT_W-1:0] fwd_data_ff, fwd_data_in;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             end_ok;
   logic             is_end;
   logic             end_accept;
   logic             byte_accept;
   logic             wr_en;
   logic [CNT_W-1:0] rd_data;
   logic [CNT_W-1:0] cnt_before;
   logic [CNT_W-1:0] cnt_after;

   // Hold end items until the result register is sure to be free.
   assign is_end     = (req_data.kind == KIND_END);
   assign end_ok     = (s2_op_ff != OP_END) && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !is_end || end_ok;
   assign accept     = req_valid && req_ready;
   assign end_accept = accept && is_end;

   // Front stage: check lengths and issue the count read.
   always_comb begin
      first_len_in  = first_len_ff;
      second_len_in = second_len_ff;
      ovf_in        = ovf_ff;
      s2_op_in      = OP_NONE;
      s2_sym_in     = req_data.symbol;
      s2_eq_in      = (first_len_ff == second_len_ff);
      s2_ovf_in     = ovf_ff;
      if (accept) begin
         case (req_data.kind)
            KIND_FIRST: begin
               if (first_len_ff >= LEN_MAX) begin
                  ovf_in = 1'b1;
               end else begin
                  first_len_in = first_len_ff + LEN_W'(1);
                  s2_op_in     = OP_ADD;
               end
            end
            KIND_SECOND: begin
               if (second_len_ff >= LEN_MAX) begin
                  ovf_in = 1'b1;
               end else begin
                  second_len_in = second_len_ff + LEN_W'(1);
                  s2_op_in      = OP_SUB;
               end
            end
            KIND_END: begin
               // Lengths are final here; start the next pair clean.
               s2_op_in      = OP_END;
               first_len_in  = '0;
               second_len_in = '0;
               ovf_in        = 1'b0;
            end
            default: begin
               s2_op_in = OP_NONE;
            end
         endcase
      end
   end

   assign byte_accept = (s2_op_in == OP_ADD) || (s2_op_in == OP_SUB);

   anachk_count_ram #(
      .DATA_W (CNT_W)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s2_sym_ff),
      .wr_data (cnt_after),
      .rd_en   (byte_accept),
      .rd_addr (req_data.symbol),
      .rd_data (rd_data)
   );

   // Update stage: pick the live count, adjust it and write it back.
   always_comb begin
      if (fwd_valid_ff && (fwd_sym_ff == s2_sym_ff)) begin
         cnt_before = fwd_data_ff;
      end else if (valid_ff[s2_sym_ff]) begin
         cnt_before = rd_data;
      end else begin
         cnt_before = '0;
      end
      if (s2_op_ff == OP_ADD) begin
         cnt_after = cnt_before + CNT_W'(1);
      end else begin
         cnt_after = cnt_before - CNT_W'(1);
      end
   end

   assign wr_en = (s2_op_ff == OP_ADD) || (s2_op_ff == OP_SUB);

   always_comb begin
      valid_in     = valid_ff;
      nz_in        = nz_ff;
      fwd_valid_in = wr_en;
      fwd_sym_in   = s2_sym_ff;
      fwd_data_in  = cnt_after;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (s2_op_ff)
         OP_ADD, OP_SUB: begin
            valid_in[s2_sym_ff] = 1'b1;
            // A step of one never wraps, so only one of these can hold.
            if (cnt_before == '0) begin
               nz_in = nz_ff + NZ_W'(1);
            end else if (cnt_after == '0) begin
               nz_in = nz_ff - NZ_W'(1);
            end
         end
         OP_END: begin
            rsp_valid_in         = 1'b1;
            rsp_data_in.is_match = !s2_ovf_ff && s2_eq_ff && (nz_ff == '0);
            rsp_data_in.too_long = s2_ovf_ff;
            // Drop every count of the finished pair.
            valid_in = '0;
            nz_in    = '0;
         end
         default: begin
            nz_in = nz_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_len_ff  <= '0;
         second_len_ff <= '0;
         ovf_ff        <= 1'b0;
         s2_op_ff      <= OP_NONE;
         valid_ff      <= '0;
         nz_ff         <= '0;
         fwd_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         ovf_ff        <= ovf_in;
         s2_op_ff      <= s2_op_in;
         valid_ff      <= valid_in;
         nz_ff         <= nz_in;
         fwd_valid_ff  <= fwd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_sym_ff   <= s2_sym_in;
      s2_eq_ff    <= s2_eq_in;
      s2_ovf_ff   <= s2_ovf_in;
      fwd_sym_ff  <= fwd_sym_in;
      fwd_data_ff <= fwd_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An end item reaching the update stage always finds the result register free.
   `ANACHK_ASSERT_NOW(a_end_finds_free_slot, s2_op_ff == OP_END, !rsp_valid_ff)
   // A new result comes from an end item that has passed through the update stage.
   `ANACHK_ASSERT_NOW(a_rsp_from_end, $rose(rsp_valid_ff), $past(end_accept, 2))
   // A word that ran over never reports a match.
   `ANACHK_ASSERT_NOW(a_long_no_match, rsp_valid_ff, !(rsp_data_ff.is_match && rsp_data_ff.too_long))
   // The cycle after an end item is taken, the word lengths restart at zero.
   `ANACHK_ASSERT_NEXT(a_len_restart, end_accept, (first_len_ff == '0) && (second_len_ff == '0))

endmodule

/* sv/anachk_count_ram.sv */
// ----------------------------------------------------------------------------
// Anagram checker count store
// One entry per symbol, one write and one registered read port.
// ----------------------------------------------------------------------------
module anachk_count_ram #(
   parameter int DATA_W = 8
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [anachk_pkg::SYM_W-1:0]  wr_addr,
   input  logic [DATA_W-1:0]             wr_data,
   input  logic                          rd_en,
   input  logic [anachk_pkg::SYM_W-1:0]  rd_addr,
   output logic [DATA_W-1:0]             rd_data
);
   import anachk_pkg::*;

   localparam int DEPTH = 1 << SYM_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read returns the old contents when it hits the entry being written.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/anagram_match_monitor.sv */
// ----------------------------------------------------------------------------
// Anagram match monitor
// Watches both channels of the anagram checker and keeps a shadow histogram
// of the two words. Each end item queues the expected verdict, and each
// result item is compared field by field with the oldest queued verdict.
// ----------------------------------------------------------------------------
module anagram_match_monitor #(
   parameter int MAX_WORD_LEN = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  anachk_pkg::req_type req_data,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  anachk_pkg::rsp_type rsp_data,
   output int                  mismatch_count,
   output int                  verdicts_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import anachk_pkg::*;

   // Shadow histogram of 16-bit counts: no nonzero count wraps to zero while MAX_WORD_LEN is below 2**16.
   logic [15:0] symbol_tally [2**SYM_W];
   int          unbalanced_symbols;
   int          first_len;
   int          second_len;
   bit          overflowed;
   rsp_type     verdict_queue [$];
   rsp_type     verdict;
   rsp_type     oldest;

   function automatic void tally_symbol(logic [SYM_W-1:0] sym, bit add);
      logic [15:0] was;
      logic [15:0] now_val;
      was = symbol_tally[sym];
      now_val = add ? was + 16'd1 : was - 16'd1;
      symbol_tally[sym] = now_val;
      if (was == 16'd0 && now_val != 16'd0)
         unbalanced_symbols++;
      else if (was != 16'd0 && now_val == 16'd0)
         unbalanced_symbols--;
   endfunction

   function automatic void clear_words();
      foreach (symbol_tally[i])
         symbol_tally[i] = '0;
      unbalanced_symbols = 0;
      first_len = 0;
      second_len = 0;
      overflowed = 1'b0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_words();
         verdict_queue.delete();
         mismatch_count = 0;
      end else begin
         if (req_valid && req_ready) begin
            case (req_data.kind)
               KIND_FIRST: begin
                  if (first_len >= MAX_WORD_LEN) begin
                     overflowed = 1'b1;
                  end else begin
                     first_len++;
                     tally_symbol(req_data.symbol, 1'b1);
                  end
               end
               KIND_SECOND: begin
                  if (second_len >= MAX_WORD_LEN) begin
                     overflowed = 1'b1;
                  end else begin
                     second_len++;
                     tally_symbol(req_data.symbol, 1'b0);
                  end
               end
               KIND_END: begin
                  verdict.too_long = overflowed;
                  verdict.is_match = !overflowed && first_len == second_len &&
                                     unbalanced_symbols == 0;
                  verdict_queue.insert(verdict_queue.size(), verdict);
                  clear_words();
               end
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (verdict_queue.size() == 0) begin
               $display("%0t: result item with no verdict pending (is_match %0b too_long %0b)",
                        $time, rsp_data.is_match, rsp_data.too_long);
               mismatch_count++;
            end else begin
               oldest = verdict_queue.pop_front();
               if (rsp_data.is_match !== oldest.is_match) begin
                  $display("%0t: is_match expected %0b, got %0b",
                           $time, oldest.is_match, rsp_data.is_match);
                  mismatch_count++;
               end
               if (rsp_data.too_long !== oldest.too_long) begin
                  $display("%0t: too_long expected %0b, got %0b",
                           $time, oldest.too_long, rsp_data.too_long);
                  mismatch_count++;
               end
            end
         end
      end
      verdicts_pending = verdict_queue.size();
   end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Anagram checker testbench
// Drives word pairs into the anagram checker: a short directed list of
// corner cases, then random pairs that are mostly true anagrams, near misses
// and over-long words, with a little noise. Both channels stall at random.
// The match monitor predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import anachk_pkg::*;

   localparam int                MAX_WORD_LEN = 64;
   localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;   // taken and dropped
   localparam int                IDLE_PCT     = 19;
   localparam int                RANDOM_ITEMS = 620;    // directed part included
   localparam int                MIN_PAIRS    = 60;
   localparam int                DRAIN_CYCLES = 10;
   localparam int                CYCLE_LIMIT  = 200000;

   typedef logic [SYM_W-1:0] byte_queue_type [$];

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      mismatch_count;
   int      verdicts_pending;

   int      item_count;   // accepted items of a real kind
   int      pair_count;   // end items sent through send_pair
   int      cycle_count;
   bit      calm;         // while set, neither side idles

   anagram_checker #(
      .MAX_WORD_LEN(MAX_WORD_LEN)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   anagram_match_monitor #(
      .MAX_WORD_LEN(MAX_WORD_LEN)
   ) match_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .mismatch_count  (mismatch_count),
      .verdicts_pending(verdicts_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Guard against a hang: a stuck handshake or a verdict that never comes.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Result side: stall at random, except during the calm stretch.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= calm || $urandom_range(99) >= IDLE_PCT;
      end
   end

   // Offer one item at a falling edge, idling first at random, and hold it
   // until the rising edge that accepts it. Valid stays high on return so
   // that back-to-back items need no gap.
   task automatic send_item(logic [KIND_W-1:0] kind, logic [SYM_W-1:0] symbol);
      @(negedge clock);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req_type'{kind: kind, symbol: symbol};
      do @(posedge clock); while (!req_ready);
      if (kind != KIND_UNUSED)
         item_count++;
   endtask

   // Drop valid and hold off until every verdict has come back.
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (verdicts_pending != 0)
         @(negedge clock);
   endtask

   // Send two words in one of three orders (first word first, second word
   // first, or a random merge), with a stray unused-kind item now and then,
   // and close the pair with an end item.
   task automatic send_pair(byte_queue_type word_a, byte_queue_type word_b);
      int order;
      bit take_a;
      order = $urandom_range(2);
      while (word_a.size() + word_b.size() > 0) begin
         if (word_a.size() == 0)
            take_a = 1'b0;
         else if (word_b.size() == 0)
            take_a = 1'b1;
         else if (order == 2)
            take_a = 1'($urandom_range(1));
         else
            take_a = (order == 0);
         if ($urandom_range(99) < 3)
            send_item(KIND_UNUSED, SYM_W'($urandom_range(255)));
         if (take_a)
            send_item(KIND_FIRST, word_a.pop_front());
         else
            send_item(KIND_SECOND, word_b.pop_front());
      end
      // The symbol of an end item is ignored; randomize it anyway.
      send_item(KIND_END, SYM_W'($urandom_range(255)));
      pair_count++;
   endtask

   // A narrow word draws from four letters, so symbols repeat and the same
   // count is hit on back-to-back bytes; a wide word uses every byte value.
   function automatic byte_queue_type random_word(int len, bit narrow);
      byte_queue_type   w;
      logic [SYM_W-1:0] sym;
      repeat (len) begin
         sym = narrow ? SYM_W'(8'h61 + $urandom_range(3)) : SYM_W'($urandom_range(255));
         w.insert(w.size(), sym);
      end
      return w;
   endfunction

   function automatic byte_queue_type scrambled(byte_queue_type w);
      int               j;
      logic [SYM_W-1:0] t;
      for (int i = w.size() - 1; i > 0; i--) begin
         j = $urandom_range(i);
         t = w[i];
         w[i] = w[j];
         w[j] = t;
      end
      return w;
   endfunction

   initial begin
      byte_queue_type   word_a;
      byte_queue_type   word_b;
      byte_queue_type   spare;
      int               shape;
      int               round;
      int               len;
      int               idx;
      bit               narrow;
      logic [SYM_W-1:0] extra;

      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      calm       = 1'b0;
      item_count = 0;
      pair_count = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: two empty words match.
      send_item(KIND_END, 8'h00);
      // Unused kind is dropped, so this pair is still empty.
      send_item(KIND_UNUSED, 8'hFF);
      send_item(KIND_UNUSED, 8'h00);
      send_item(KIND_END, 8'hFF);
      // Extreme symbols, in reverse order in the second word.
      send_item(KIND_FIRST, 8'h00);
      send_item(KIND_FIRST, 8'hFF);
      send_item(KIND_SECOND, 8'hFF);
      send_item(KIND_SECOND, 8'h00);
      send_item(KIND_END, 8'h00);
      // Same length, one symbol differs.
      send_item(KIND_FIRST, 8'h41);
      send_item(KIND_FIRST, 8'h41);
      send_item(KIND_SECOND, 8'h41);
      send_item(KIND_SECOND, 8'h42);
      send_item(KIND_END, 8'h00);
      // Lengths differ.
      send_item(KIND_FIRST, 8'h7F);
      send_item(KIND_SECOND, 8'h7F);
      send_item(KIND_SECOND, 8'h7F);
      send_item(KIND_END, 8'h00);
      // Second word first: the count goes negative and comes back to zero.
      send_item(KIND_SECOND, 8'h80);
      send_item(KIND_FIRST, 8'h80);
      send_item(KIND_END, 8'h80);

      // Let every directed verdict come home before the random part.
      hold_until_drained();

      round = 0;
      while (item_count < RANDOM_ITEMS || pair_count < MIN_PAIRS) begin
         // A stretch with no stalls on either side.
         calm = (round >= 20 && round < 30);
         if (round == 40)
            hold_until_drained();

         shape = $urandom_range(99);
         if (round == 3 || round == 12)
            shape = 90;   // force a word past the limit
         else if (round == 7)
            shape = 94;   // force both words exactly at the limit
         narrow = 1'($urandom_range(1));
         len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
         word_a = random_word(len, narrow);

         if (shape < 55) begin
            // True anagram.
            send_pair(word_a, scrambled(word_a));
         end else if (shape < 70) begin
            // Same length, one byte altered; an empty word gains a byte instead.
            word_b = scrambled(word_a);
            if (word_b.size() == 0) begin
               extra = SYM_W'($urandom_range(255));
               word_b.insert(word_b.size(), extra);
            end else begin
               idx = $urandom_range(word_b.size() - 1);
               word_b[idx] = word_b[idx] + SYM_W'($urandom_range(1, 255));
            end
            send_pair(word_a, word_b);
         end else if (shape < 80) begin
            // Length off by one.
            word_b = scrambled(word_a);
            if (word_b.size() == 0 || $urandom_range(1)) begin
               extra = narrow ? 8'h61 : SYM_W'($urandom_range(255));
               word_b.insert(word_b.size(), extra);
            end else begin
               void'(word_b.pop_back());
            end
            send_pair(word_a, word_b);
         end else if (shape < 88) begin
            // Two unrelated words.
            send_pair(word_a, random_word($urandom_range(0, 8), narrow));
         end else if (shape < 93) begin
            // One or both words too long: the second is a scrambled copy of the first,
            // cut to the limit half the time, and the two may then swap places.
            word_a = random_word(MAX_WORD_LEN + 1 + $urandom_range(3), narrow);
            word_b = scrambled(word_a);
            if ($urandom_range(1)) begin
               while (word_b.size() > MAX_WORD_LEN)
                  void'(word_b.pop_back());
            end
            if ($urandom_range(1)) begin
               spare  = word_a;
               word_a = word_b;
               word_b = spare;
            end
            send_pair(word_a, word_b);
         end else if (shape < 96) begin
            // Both words exactly at the limit.
            word_a = random_word(MAX_WORD_LEN, narrow);
            send_pair(word_a, scrambled(word_a));
         end else begin
            // Noise: any kind, any symbol, end items included.
            repeat ($urandom_range(1, 6))
               send_item(KIND_W'($urandom_range(3)), SYM_W'($urandom_range(255)));
         end
         round++;
      end

      // Drop valid, wait for the last verdicts, then let the pipe settle.
      @(negedge clock);
      req_valid <= 1'b0;
      calm = 1'b0;
      while (verdicts_pending != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
